// ===== sv/erw_pkg.sv =====
// Shared types and constants of the efficiency ratio window block.
// Depends on nothing; erw_ctrl, erw_dp and efficiency_ratio_window import it.
package erw_pkg;

    localparam int PRICE_W        = 32;   // width of one price sample
    localparam int PERIOD_W       = 7;    // width of the period register
    localparam int PERIOD_RESET   = 10;   // period after reset
    localparam int MAX_PERIOD_DEF = 64;   // default window capacity in changes
    localparam int FRAC_BITS_DEF  = 16;   // default fraction bits of the ratio

    // Controller to datapath: one strobe per step of an item.
    typedef struct packed {
        logic take;      // latch the accepted price
        logic rd_b;      // read the slot after the write slot
        logic upd;       // capture oldest price, write ring, form new change
        logic sub;       // retire the change leaving the window
        logic add;       // add the new change, advance fill and slot
        logic chk;       // decide saturation, load divider
        logic div_step;  // one restoring divide step
        logic load_out;  // move the ratio into the output register
        logic cfg_wr;    // write the period, empty the window
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic emit;      // this item produces a ratio
        logic one;       // ratio saturates at 1.0
        logic out_free;  // output register can take a ratio this cycle
    } t_stat;

endpackage

// ===== sv/erw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module erw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/erw_ctrl.sv =====
// Sequencer of the efficiency ratio window: steps one item through
// ring access, sum update, divide and output load. Depends on erw_pkg.
module erw_ctrl import erw_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_cfg_valid,
    output logic  o_cfg_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int CW = $clog2(FRAC_BITS);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RDA  = 9'b000000010,
        S_RDB  = 9'b000000100,
        S_UPD  = 9'b000001000,
        S_SUB  = 9'b000010000,
        S_ADD  = 9'b000100000,
        S_CHK  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.cfg_wr = i_cfg_valid;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_RDA;
                end
            end
            S_RDA: n_state = S_RDB;
            S_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_cnt     = '0;
                priority if (!i_stat.emit) begin
                    n_state = S_IDLE;
                end else if (i_stat.one) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(FRAC_BITS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/erw_dp.sv =====
// Datapath of the efficiency ratio window: price ring, path sum, flat run,
// restoring divider and output register. Depends on erw_pkg and erw_ram.
module erw_dp import erw_pkg::*; #(
    parameter int MAX_PERIOD = MAX_PERIOD_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [PRICE_W-1:0]  i_price,
    input  logic [PERIOD_W-1:0] i_cfg_data,
    input  logic                i_m_ready,
    output logic                o_m_valid,
    output logic [FRAC_BITS:0]  o_ratio
);

    localparam int DEPTH = MAX_PERIOD + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_PERIOD + 2);
    localparam int SUM_W = PRICE_W + $clog2(MAX_PERIOD);
    localparam int RW    = FRAC_BITS + 1;
    localparam logic [RW-1:0] ONE_Q = RW'(1) << FRAC_BITS;

    function automatic logic [PW-1:0] clamp_period(input int v);
        logic [PW-1:0] res;
        if (v < 1) begin
            res = PW'(1);
        end else if (v > MAX_PERIOD) begin
            res = PW'(MAX_PERIOD);
        end else begin
            res = PW'(v);
        end
        return res;
    endfunction

    function automatic logic [PRICE_W-1:0] abs_diff(input logic [PRICE_W-1:0] x,
                                                    input logic [PRICE_W-1:0] y);
        return (x >= y) ? x - y : y - x;
    endfunction

    logic [PW-1:0]        r_p, r_seen, r_flat, n_seen, n_flat, flat_inc;
    logic [AW-1:0]        r_slot, slot_next;
    logic [SUM_W-1:0]     r_sum, n_sum, sum_sub, sum_add, d_old;
    logic [PRICE_W-1:0]   r_price, r_prev, r_a, r_b, r_dnew, r_mag, rd_data;
    logic                 r_emit, r_one, r_m_valid, full;
    logic [SUM_W-1:0]     r_rem;
    logic [SUM_W:0]       rem2;
    logic                 ge;
    logic [FRAC_BITS-1:0] r_quo;
    logic [RW-1:0]        r_ratio;

    assign slot_next = (PW'(r_slot) == r_p) ? '0 : r_slot + 1'b1;
    assign full      = (r_seen > r_p);

    erw_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_waddr (r_slot),
        .i_wdata (r_price),
        .i_raddr (i_cmd.rd_b ? slot_next : r_slot),
        .o_rdata (rd_data)
    );

    // Path sum: retire the leaving change, then add the new one; a flat run of period changes clears the sum.
    always_comb begin
        d_old    = SUM_W'(abs_diff(r_b, r_a));
        sum_sub  = (r_sum >= d_old) ? r_sum - d_old : '0;
        sum_add  = r_sum + SUM_W'(r_dnew);
        flat_inc = (r_flat < r_p) ? r_flat + 1'b1 : r_flat;
        n_sum    = r_sum;
        n_flat   = r_flat;
        n_seen   = full ? r_seen : r_seen + 1'b1;
        if (i_cmd.sub && full) begin
            n_sum = sum_sub;
        end
        if (i_cmd.add && (r_seen != '0)) begin
            n_sum  = sum_add;
            n_flat = (r_dnew == '0) ? flat_inc : '0;
            if ((r_dnew == '0) && (flat_inc >= r_p)) begin
                n_flat = r_p;
                n_sum  = '0;
            end
        end
    end

    // One restoring divide step.
    assign rem2 = {r_rem, 1'b0};
    assign ge   = (rem2 >= {1'b0, r_sum});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p       <= clamp_period(PERIOD_RESET);
            r_slot    <= '0;
            r_seen    <= '0;
            r_flat    <= '0;
            r_sum     <= '0;
            r_emit    <= 1'b0;
            r_one     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_wr) begin
                r_p    <= clamp_period(int'(i_cfg_data));
                r_slot <= '0;
                r_seen <= '0;
                r_flat <= '0;
                r_sum  <= '0;
            end else begin
                r_sum  <= n_sum;
                r_flat <= n_flat;
                if (i_cmd.add) begin
                    r_seen <= n_seen;
                    r_slot <= slot_next;
                    r_emit <= (n_seen > r_p);
                end
            end
            if (i_cmd.chk) begin
                r_one <= ({{(SUM_W - PRICE_W){1'b0}}, r_mag} >= r_sum);
            end
            if (i_cmd.load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_price <= i_price;
        end
        if (i_cmd.rd_b) begin
            r_a <= rd_data;
        end
        if (i_cmd.upd) begin
            r_b    <= rd_data;
            r_dnew <= abs_diff(r_price, r_prev);
        end
        if (i_cmd.add) begin
            r_prev <= r_price;
            r_mag  <= abs_diff(r_price, r_b);
        end
        if (i_cmd.chk) begin
            r_rem <= SUM_W'(r_mag);
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? SUM_W'(rem2 - {1'b0, r_sum}) : SUM_W'(rem2);
            r_quo <= {r_quo[FRAC_BITS-2:0], ge};
        end
        if (i_cmd.load_out) begin
            r_ratio <= r_one ? ONE_Q : {1'b0, r_quo};
        end
    end

    assign o_stat.emit     = r_emit;
    assign o_stat.one      = ({{(SUM_W - PRICE_W){1'b0}}, r_mag} >= r_sum);
    assign o_stat.out_free = !r_m_valid || i_m_ready;
    assign o_m_valid       = r_m_valid;
    assign o_ratio         = r_ratio;

endmodule

// ===== sv/efficiency_ratio_window.sv =====
// Efficiency ratio window: each price beat on the slave stream enters a ring
// of the last period+1 prices; once the window is full every beat yields one
// ratio |net change| / sum of |one-bar changes| in unsigned Q1.FRAC_BITS,
// saturated at 1.0 (also when the path sum is zero or not above the net
// change). The first period beats after reset or a period write give no
// result. Each item steps through the ring reads and write, sum update and
// saturation check, then the bit-serial restoring divider that produces one
// quotient bit a cycle, and is loaded into the output register; saturated
// ratios skip the divider, items that only fill the window end after the
// check. A finished ratio waits in the output register while the next price
// is accepted. Write the period only while the block is idle; the write
// empties the window. Period 0 acts as 1 and values above MAX_PERIOD act
// as MAX_PERIOD. Depends on erw_pkg, erw_ctrl, erw_dp and erw_ram.
module efficiency_ratio_window import erw_pkg::*; #(
    parameter int MAX_PERIOD = MAX_PERIOD_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave stream: tdata[31:0] = price
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [PRICE_W-1:0]                   s_axis_tdata,
    // master stream: tdata[FRAC_BITS:0] = ratio, upper bits zero
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((FRAC_BITS + 8) / 8) * 8-1:0] m_axis_tdata,
    // period register write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [PERIOD_W-1:0]                  i_cfg_data
);

    localparam int RW     = FRAC_BITS + 1;
    localparam int OUT_TW = ((FRAC_BITS + 8) / 8) * 8;
    localparam logic [RW-1:0] ONE_Q = RW'(1) << FRAC_BITS;

    t_cmd          cmd;
    t_stat         stat;
    logic [RW-1:0] ratio;

    // Sequence one item at a time through the datapath.
    erw_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Hold the ring, sums, divider and output register.
    erw_dp #(
        .MAX_PERIOD (MAX_PERIOD),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_price    (s_axis_tdata),
        .i_cfg_data (i_cfg_data),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_ratio    (ratio)
    );

    // Pad the ratio to whole bytes.
    assign m_axis_tdata = OUT_TW'(ratio);

    // A ratio never exceeds 1.0.
    a_ratio_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[FRAC_BITS:0] <= ONE_Q))
        else $error("ratio above 1.0");

    // An accepted price keeps the block busy on the following cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken twice in a row");

    // A new result appears only as the end of an item's sequence.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result loaded while idle");

    // Configuration is taken only when no item is in flight.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> s_axis_tready)
        else $error("period written during an item");

endmodule
